FILE: sv/tilt_hump_event_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt hump event detector
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TILT_HUMP_EVENT_DETECTOR_TOP_DEFINES_SVH
`define TILT_HUMP_EVENT_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define THED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thed assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define THED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thed assertion failed");

`endif

FILE: sv/thed_pkg.sv
// ----------------------------------------------------------------------------
// thed_pkg
// Types, codes, constants and the arctangent table of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package thed_pkg;

  localparam int WINDOW_DEPTH_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int ZW           = 26;
  localparam int KINV_Q16     = 39797;
  localparam int TIME_W       = 32;
  localparam int TILT_W       = 15;
  localparam int PITCH_LIMIT  = 5760;

  localparam logic [2:0] CFG_LEVEL_PITCH     = 3'd0;
  localparam logic [2:0] CFG_START_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_LEVEL_BAND      = 3'd2;
  localparam logic [2:0] CFG_MIN_PHASE       = 3'd3;
  localparam logic [2:0] CFG_CANCEL_LEVEL    = 3'd4;
  localparam logic [2:0] CFG_FINISH_LEVEL    = 3'd5;
  localparam logic [2:0] CFG_EVENT_TIMEOUT   = 3'd6;

  localparam logic [1:0] PH_WAITING    = 2'd0;
  localparam logic [1:0] PH_CLIMBING   = 2'd1;
  localparam logic [1:0] PH_DESCENDING = 2'd2;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_CLIMB      = 3'd1;
  localparam logic [2:0] EV_DESCENT    = 3'd2;
  localparam logic [2:0] EV_DONE_CLIMB = 3'd3;
  localparam logic [2:0] EV_DONE       = 3'd4;
  localparam logic [2:0] EV_CANCEL     = 3'd5;
  localparam logic [2:0] EV_TIMEOUT    = 3'd6;

  typedef struct packed {
    logic signed [13:0] level_ref;
    logic [12:0]        start_threshold;
    logic [12:0]        level_band;
    logic [15:0]        phase_min_ms;
    logic [15:0]        cancel_level_ms;
    logic [15:0]        finish_level_ms;
    logic [19:0]        hump_limit_ms;
  } cfg_t;

  // atan(2^-i) in 1/65536 degree.
  function automatic logic [22:0] atan_q16(input logic [4:0] idx);
    logic [22:0] v;
    unique case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/thed_front.sv
// ----------------------------------------------------------------------------
// thed_front
// Accepts samples, keeps the sample ring and the running axis sums.
// ----------------------------------------------------------------------------
`default_nettype none

module thed_front #(
  parameter int DEPTH = thed_pkg::WINDOW_DEPTH_DEF,
  parameter int SB    = thed_pkg::SAMPLE_BITS_DEF,
  parameter int SUMW  = SB + $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic signed [SB-1:0]   in_accel_x,
  input  logic signed [SB-1:0]   in_accel_y,
  input  logic signed [SB-1:0]   in_accel_z,
  input  logic [31:0]            in_time_ms,
  output logic                   q_push,
  input  logic                   q_full,
  output logic                   q_win_full,
  output logic signed [SUMW-1:0] q_sx,
  output logic signed [SUMW-1:0] q_sy,
  output logic signed [SUMW-1:0] q_sz,
  output logic [31:0]            q_time
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [3*SB-1:0] ring_mem [DEPTH];
  logic [3*SB-1:0] rd_r;
  logic [3*SB-1:0] smp_r;
  logic [31:0]     time_r;
  logic            busy_r;
  logic [PW-1:0]   ptr_r;
  logic [FW-1:0]   fill_r;
  logic signed [SUMW-1:0] sx_r, sy_r, sz_r;
  logic signed [SUMW-1:0] sx_nxt, sy_nxt, sz_nxt;
  logic            wrapped;
  logic            accept;

  assign in_full = busy_r | q_full;
  assign accept  = in_push & ~in_full;
  assign wrapped = (fill_r >= FW'(DEPTH));

  always_comb begin
    logic signed [SB-1:0] ox, oy, oz;
    ox = wrapped ? $signed(rd_r[3*SB-1:2*SB]) : '0;
    oy = wrapped ? $signed(rd_r[2*SB-1:SB])   : '0;
    oz = wrapped ? $signed(rd_r[SB-1:0])      : '0;
    sx_nxt = sx_r - SUMW'(ox) + SUMW'($signed(smp_r[3*SB-1:2*SB]));
    sy_nxt = sy_r - SUMW'(oy) + SUMW'($signed(smp_r[2*SB-1:SB]));
    sz_nxt = sz_r - SUMW'(oz) + SUMW'($signed(smp_r[SB-1:0]));
  end

  assign q_push     = busy_r;
  assign q_sx       = sx_nxt;
  assign q_sy       = sy_nxt;
  assign q_sz       = sz_nxt;
  assign q_time     = time_r;
  assign q_win_full = (fill_r >= FW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r  <= {in_accel_x, in_accel_y, in_accel_z};
      time_r <= in_time_ms;
      rd_r   <= ring_mem[ptr_r];
    end
    if (busy_r) begin
      ring_mem[ptr_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= '0;
      fill_r <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      sz_r   <= '0;
    end else begin
      busy_r <= accept;
      if (busy_r) begin
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
        sz_r  <= sz_nxt;
        ptr_r <= (ptr_r == PW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
        if (!wrapped) fill_r <= fill_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/thed_queue.sv
// ----------------------------------------------------------------------------
// thed_queue
// Two-entry queue that decouples the sample front from the angle back end.
// ----------------------------------------------------------------------------
`default_nettype none

module thed_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

FILE: sv/thed_back.sv
// ----------------------------------------------------------------------------
// thed_back
// Two CORDIC vectoring passes, tilt, hump state machine and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module thed_back #(
  parameter int SUMW  = 15,
  parameter int STEPS = thed_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  thed_pkg::cfg_t         cfg,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic                   q_win_full,
  input  logic signed [SUMW-1:0] q_sx,
  input  logic signed [SUMW-1:0] q_sy,
  input  logic signed [SUMW-1:0] q_sz,
  input  logic [31:0]            q_time,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic                   out_window_full,
  output logic signed [14:0]     out_tilt,
  output logic [1:0]             out_hump_phase,
  output logic [2:0]             out_event_code,
  output logic [15:0]            out_hump_total,
  output logic [15:0]            out_highest_hump_index,
  output logic [13:0]            out_highest_climb,
  output logic signed [14:0]     out_climb_peak,
  output logic signed [14:0]     out_descent_peak
);

  localparam int WW = SUMW + 20;
  localparam int CW = $clog2(STEPS);
  localparam int ZW = thed_pkg::ZW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_P1     = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_P2     = 3'd3;
  localparam logic [2:0] S_RND    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0]             st_r;
  logic signed [WW-1:0]   x_r, y_r;
  logic signed [ZW-1:0]   z_r;
  logic [CW-1:0]          cnt_r;
  logic signed [SUMW-1:0] sy_r;
  logic [31:0]            now_r;
  logic                   full_r;
  logic signed [14:0]     tilt_r;
  logic                   out_valid_r;

  // Detector state.
  logic [1:0]         phase_r, phase_nxt;
  logic [31:0]        ev_start_r, ev_start_nxt;
  logic [31:0]        ph_start_r, ph_start_nxt;
  logic [31:0]        lv_start_r, lv_start_nxt;
  logic               lv_on_r, lv_on_nxt;
  logic signed [14:0] pk_up_r, pk_up_nxt;
  logic signed [14:0] pk_dn_r, pk_dn_nxt;
  logic [15:0]        humps_r, humps_nxt;
  logic [15:0]        best_r, best_nxt;
  logic [13:0]        climb_r, climb_nxt;
  logic [2:0]         ev_nxt;

  logic                 last_step;
  logic                 commit;
  logic signed [WW-1:0] x_step, y_step, dx, dy;
  logic signed [ZW-1:0] z_step, atan_v;
  logic signed [WW+16:0] prod;

  assign last_step = (cnt_r == CW'(STEPS - 1));
  assign commit    = (st_r == S_COMMIT) && (!out_valid_r || out_pop);
  assign q_pop     = (st_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;

  always_comb begin
    dx     = y_r >>> cnt_r;
    dy     = x_r >>> cnt_r;
    atan_v = ZW'(signed'({1'b0, thed_pkg::atan_q16(5'(cnt_r))}));
    if (!y_r[WW-1]) begin
      x_step = x_r + dx;
      y_step = y_r - dy;
      z_step = z_r + atan_v;
    end else begin
      x_step = x_r - dx;
      y_step = y_r + dy;
      z_step = z_r - atan_v;
    end
    prod = (WW+17)'(x_r) * (WW+17)'(thed_pkg::KINV_Q16) + (WW+17)'(32768);
  end

  // Hump state machine for the sample in tilt_r.
  always_comb begin
    logic [14:0]        mag;
    logic               level;
    logic signed [15:0] t16, thr16;
    logic [31:0]        dph, dlv, dev;
    logic               cmp_hump;
    logic [15:0]        inc;

    phase_nxt    = phase_r;
    ev_start_nxt = ev_start_r;
    ph_start_nxt = ph_start_r;
    lv_start_nxt = lv_start_r;
    lv_on_nxt    = lv_on_r;
    pk_up_nxt    = pk_up_r;
    pk_dn_nxt    = pk_dn_r;
    humps_nxt    = humps_r;
    best_nxt     = best_r;
    climb_nxt    = climb_r;
    ev_nxt       = thed_pkg::EV_NONE;
    cmp_hump     = 1'b0;

    mag   = tilt_r[14] ? 15'(-tilt_r) : 15'(tilt_r);
    level = {1'b0, mag} < {3'b0, cfg.level_band};
    t16   = {tilt_r[14], tilt_r};
    thr16 = signed'({3'b0, cfg.start_threshold});
    dph   = now_r - ph_start_r;
    dlv   = now_r - lv_start_r;
    dev   = now_r - ev_start_r;

    if (full_r) begin
      unique case (phase_r)
        thed_pkg::PH_CLIMBING: begin
          if (tilt_r > pk_up_r) pk_up_nxt = tilt_r;
          if (t16 < -thr16 && dph >= {16'b0, cfg.phase_min_ms}) begin
            phase_nxt    = thed_pkg::PH_DESCENDING;
            ph_start_nxt = now_r;
            pk_dn_nxt    = tilt_r;
            lv_on_nxt    = 1'b0;
            ev_nxt       = thed_pkg::EV_DESCENT;
          end else if (level) begin
            if (!lv_on_r) begin
              lv_on_nxt    = 1'b1;
              lv_start_nxt = now_r;
            end else if (dlv >= {16'b0, cfg.cancel_level_ms}) begin
              phase_nxt = thed_pkg::PH_WAITING;
              ev_nxt    = thed_pkg::EV_CANCEL;
            end
          end else begin
            lv_on_nxt = 1'b0;
          end
          if (phase_nxt == thed_pkg::PH_CLIMBING &&
              dev > {12'b0, cfg.hump_limit_ms}) begin
            phase_nxt = thed_pkg::PH_WAITING;
            ev_nxt    = thed_pkg::EV_TIMEOUT;
          end
        end
        thed_pkg::PH_DESCENDING: begin
          if (tilt_r < pk_dn_r) pk_dn_nxt = tilt_r;
          if (t16 > thr16 && dph >= {16'b0, cfg.phase_min_ms}) begin
            cmp_hump     = 1'b1;
            phase_nxt    = thed_pkg::PH_CLIMBING;
            ev_start_nxt = now_r;
            ph_start_nxt = now_r;
            pk_up_nxt    = tilt_r;
            pk_dn_nxt    = '0;
            lv_on_nxt    = 1'b0;
            ev_nxt       = thed_pkg::EV_DONE_CLIMB;
          end else if (level) begin
            if (!lv_on_r) begin
              lv_on_nxt    = 1'b1;
              lv_start_nxt = now_r;
            end else if (dlv >= {16'b0, cfg.finish_level_ms}) begin
              cmp_hump  = 1'b1;
              phase_nxt = thed_pkg::PH_WAITING;
              lv_on_nxt = 1'b0;
              ev_nxt    = thed_pkg::EV_DONE;
            end
          end else begin
            lv_on_nxt = 1'b0;
          end
          if (phase_nxt == thed_pkg::PH_DESCENDING &&
              dev > {12'b0, cfg.hump_limit_ms}) begin
            phase_nxt = thed_pkg::PH_WAITING;
            ev_nxt    = thed_pkg::EV_TIMEOUT;
          end
        end
        default: begin
          phase_nxt = thed_pkg::PH_WAITING;
          if (t16 > thr16) begin
            phase_nxt    = thed_pkg::PH_CLIMBING;
            ev_start_nxt = now_r;
            ph_start_nxt = now_r;
            pk_up_nxt    = tilt_r;
            pk_dn_nxt    = '0;
            lv_on_nxt    = 1'b0;
            ev_nxt       = thed_pkg::EV_CLIMB;
          end
        end
      endcase
    end

    // The climb peak used here is the one held before this sample.
    inc = (humps_r == 16'hFFFF) ? humps_r : humps_r + 16'd1;
    if (cmp_hump) begin
      humps_nxt = inc;
      if (pk_up_r > signed'({1'b0, climb_r})) begin
        climb_nxt = 14'(pk_up_r);
        best_nxt  = inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] pz;
    logic signed [13:0]   pitch;
    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          x_r    <= (q_sx[SUMW-1] ? -WW'(q_sx) : WW'(q_sx)) <<< 16;
          y_r    <= WW'(q_sz) <<< 16;
          z_r    <= '0;
          cnt_r  <= '0;
          sy_r   <= q_sy;
          now_r  <= q_time;
          full_r <= q_win_full;
          tilt_r <= '0;
        end
      end
      S_P1, S_P2: begin
        x_r   <= x_step;
        y_r   <= y_step;
        if (st_r == S_P2) z_r <= z_step;
        cnt_r <= last_step ? '0 : cnt_r + 1'b1;
      end
      S_MUL: begin
        x_r <= WW'(prod >>> 16);
        y_r <= WW'(sy_r) <<< 16;
      end
      S_RND: begin
        if (!z_r[ZW-1]) pz = (z_r + ZW'(512)) >>> 10;
        else            pz = -((-z_r + ZW'(512)) >>> 10);
        zr = pz;
        if (zr > ZW'(thed_pkg::PITCH_LIMIT))       pitch = 14'(thed_pkg::PITCH_LIMIT);
        else if (zr < -ZW'(thed_pkg::PITCH_LIMIT)) pitch = -14'(thed_pkg::PITCH_LIMIT);
        else                                        pitch = 14'(zr);
        if (sy_r == '0) pitch = '0;
        tilt_r <= 15'(cfg.level_ref) - 15'(pitch);
      end
      default: begin
      end
    endcase
    if (commit) begin
      out_window_full        <= full_r;
      out_tilt               <= tilt_r;
      out_hump_phase         <= phase_nxt;
      out_event_code         <= ev_nxt;
      out_hump_total         <= humps_nxt;
      out_highest_hump_index <= best_nxt;
      out_highest_climb      <= climb_nxt;
      out_climb_peak         <= pk_up_nxt;
      out_descent_peak       <= pk_dn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= thed_pkg::PH_WAITING;
      ev_start_r  <= '0;
      ph_start_r  <= '0;
      lv_start_r  <= '0;
      lv_on_r     <= 1'b0;
      pk_up_r     <= '0;
      pk_dn_r     <= '0;
      humps_r     <= '0;
      best_r      <= '0;
      climb_r     <= '0;
    end else begin
      unique case (st_r)
        S_IDLE:   if (!q_empty) st_r <= q_win_full ? S_P1 : S_COMMIT;
        S_P1:     if (last_step) st_r <= S_MUL;
        S_MUL:    st_r <= S_P2;
        S_P2:     if (last_step) st_r <= S_RND;
        S_RND:    st_r <= S_COMMIT;
        S_COMMIT: if (commit) st_r <= S_IDLE;
        default:  st_r <= S_IDLE;
      endcase
      if (commit) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        ev_start_r  <= ev_start_nxt;
        ph_start_r  <= ph_start_nxt;
        lv_start_r  <= lv_start_nxt;
        lv_on_r     <= lv_on_nxt;
        pk_up_r     <= pk_up_nxt;
        pk_dn_r     <= pk_dn_nxt;
        humps_r     <= humps_nxt;
        best_r      <= best_nxt;
        climb_r     <= climb_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/tilt_hump_event_detector_top.sv
// ----------------------------------------------------------------------------
// tilt_hump_event_detector_top
// Pitch from a sliding accelerometer window and hump event detection.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        word
//   in_       input      in_push/in_full  x, y, z sample and time stamp
//   out_      output     out_pop/out_empty  one status word per sample
//   cfg_      input      cfg_we           register index and data
//
// A sample passes the front as a ring read, then a sum update, and the back
// as IDLE, the first CORDIC pass, MUL, the second pass, RND and COMMIT; the
// shared CORDIC stage is run once per pass. Samples before the window is full
// skip the CORDIC and go from IDLE straight to COMMIT.
// Reset is synchronous and active low; no clearing pass is needed.
// The result register lets the back start the next word while a result
// waits; the two-entry queue lets the front keep taking samples meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_hump_event_detector_top #(
  parameter int WINDOW_DEPTH = thed_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = thed_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = thed_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  logic [31:0]                  in_time_ms,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_window_full,
  output logic signed [14:0]           out_tilt,
  output logic [1:0]                   out_hump_phase,
  output logic [2:0]                   out_event_code,
  output logic [15:0]                  out_hump_total,
  output logic [15:0]                  out_highest_hump_index,
  output logic [13:0]                  out_highest_climb,
  output logic signed [14:0]           out_climb_peak,
  output logic signed [14:0]           out_descent_peak,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [19:0]                  cfg_wdata
);

  // The window sum grows by log2 of the depth over one sample.
  localparam int SUMW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int QW   = 1 + 3 * SUMW + 32;

  thed_pkg::cfg_t cfg_r;

  // Configuration registers; writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_ref       <= '0;
      cfg_r.start_threshold <= 13'd320;
      cfg_r.level_band      <= 13'd128;
      cfg_r.phase_min_ms    <= 16'd300;
      cfg_r.cancel_level_ms <= 16'd800;
      cfg_r.finish_level_ms <= 16'd480;
      cfg_r.hump_limit_ms   <= 20'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thed_pkg::CFG_LEVEL_PITCH:     cfg_r.level_ref       <= signed'(cfg_wdata[13:0]);
        thed_pkg::CFG_START_THRESHOLD: cfg_r.start_threshold <= cfg_wdata[12:0];
        thed_pkg::CFG_LEVEL_BAND:      cfg_r.level_band      <= cfg_wdata[12:0];
        thed_pkg::CFG_MIN_PHASE:       cfg_r.phase_min_ms    <= cfg_wdata[15:0];
        thed_pkg::CFG_CANCEL_LEVEL:    cfg_r.cancel_level_ms <= cfg_wdata[15:0];
        thed_pkg::CFG_FINISH_LEVEL:    cfg_r.finish_level_ms <= cfg_wdata[15:0];
        thed_pkg::CFG_EVENT_TIMEOUT:   cfg_r.hump_limit_ms   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  logic                   f_push, q_full, q_empty, q_pop;
  logic                   f_win, b_win;
  logic signed [SUMW-1:0] f_sx, f_sy, f_sz, b_sx, b_sy, b_sz;
  logic [31:0]            f_time, b_time;
  logic [QW-1:0]          q_out;

  thed_front #(
    .DEPTH (WINDOW_DEPTH),
    .SB    (SAMPLE_BITS),
    .SUMW  (SUMW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .in_time_ms (in_time_ms),
    .q_push     (f_push),
    .q_full     (q_full),
    .q_win_full (f_win),
    .q_sx       (f_sx),
    .q_sy       (f_sy),
    .q_sz       (f_sz),
    .q_time     (f_time)
  );

  // The front only pushes into a queue that had room when it took the sample.
  thed_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_win, f_sx, f_sy, f_sz, f_time}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  assign {b_win, b_sx, b_sy, b_sz, b_time} = q_out;

  thed_back #(
    .SUMW  (SUMW),
    .STEPS (CORDIC_STEPS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_empty                (q_empty),
    .q_pop                  (q_pop),
    .q_win_full             (b_win),
    .q_sx                   (b_sx),
    .q_sy                   (b_sy),
    .q_sz                   (b_sz),
    .q_time                 (b_time),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_window_full        (out_window_full),
    .out_tilt               (out_tilt),
    .out_hump_phase         (out_hump_phase),
    .out_event_code         (out_event_code),
    .out_hump_total         (out_hump_total),
    .out_highest_hump_index (out_highest_hump_index),
    .out_highest_climb      (out_highest_climb),
    .out_climb_peak         (out_climb_peak),
    .out_descent_peak       (out_descent_peak)
  );

endmodule

`default_nettype wire

FILE: sv/thed_checker.sv
// ----------------------------------------------------------------------------
// thed_checker
// Port-level checks on the result channel of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilt_hump_event_detector_top_defines.svh"

module thed_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic              out_window_full,
  input logic signed [14:0] out_tilt,
  input logic [1:0]        out_hump_phase,
  input logic [2:0]        out_event_code
);

  // A waiting word holds until it is taken.
  `THED_ASSERT_NXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_tilt))

  // Before the window fills, no tilt, no event and the machine still waits.
  `THED_ASSERT_IMP(a_warmup, !out_empty && !out_window_full, out_tilt == 15'sd0 && out_event_code == thed_pkg::EV_NONE && out_hump_phase == thed_pkg::PH_WAITING)

  // Events that end a hump leave the machine waiting.
  `THED_ASSERT_IMP(a_end_wait, !out_empty && (out_event_code == thed_pkg::EV_DONE || out_event_code == thed_pkg::EV_CANCEL || out_event_code == thed_pkg::EV_TIMEOUT), out_hump_phase == thed_pkg::PH_WAITING)

  // A descent event leaves the machine descending.
  `THED_ASSERT_IMP(a_desc, !out_empty && out_event_code == thed_pkg::EV_DESCENT, out_hump_phase == thed_pkg::PH_DESCENDING)

endmodule

bind tilt_hump_event_detector_top thed_checker u_thed_checker (.*);

`default_nettype wire
